// ===== src/grca_pkg.sv =====
`default_nettype none

package grca_pkg;

   localparam int CostWidth  = 32;
   localparam int ColWidth   = 5;
   localparam int CountWidth = 6;
   localparam int MaskCols   = 32;
   localparam logic [CountWidth-1:0] CountMax = 6'd63;

   typedef logic signed [CostWidth-1:0] cost_type;
   typedef logic [ColWidth-1:0]         col_type;
   typedef logic [CountWidth-1:0]       count_type;
   typedef logic [MaskCols-1:0]         mask_type;

   typedef struct packed {
      logic    valid;
      col_type winner;
   } result_type;

endpackage

`default_nettype wire

// ===== src/grca_search.sv =====
`default_nettype none

module grca_search #(
   parameter int MAX_COLS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_en,
   input  wire grca_pkg::cost_type   cost_value,
   input  wire logic                 row_end,
   input  wire logic                 matrix_end,
   output grca_pkg::result_type      result,
   output grca_pkg::mask_type        taken_mask
);
   import grca_pkg::*;

   localparam int ColLimit = (MAX_COLS < MaskCols) ? MAX_COLS : MaskCols;

   mask_type  taken_ff, taken_in;
   count_type count_ff, count_in;
   cost_type  best_value_ff, best_value_in;
   col_type   best_col_ff, best_col_in;

   logic      qualifies;
   cost_type  cand_value;
   col_type   cand_col;

   always_comb begin
      qualifies = ({1'b0, count_ff} < 7'(ColLimit)) && !taken_ff[count_ff[ColWidth-1:0]]
                  && (cost_value >= best_value_ff);
      cand_value = qualifies ? cost_value : best_value_ff;
      cand_col   = qualifies ? count_ff[ColWidth-1:0] : best_col_ff;

      taken_in      = taken_ff;
      count_in      = count_ff;
      best_value_in = best_value_ff;
      best_col_in   = best_col_ff;
      if (step_en) begin
         if (row_end) begin
            if (matrix_end) begin
               taken_in = '0;
            end else begin
               taken_in = taken_ff | (mask_type'(1) << cand_col);
            end
            count_in      = '0;
            best_value_in = '0;
            best_col_in   = '0;
         end else begin
            if (count_ff != CountMax) begin
               count_in = count_ff + count_type'(1);
            end
            best_value_in = cand_value;
            best_col_in   = cand_col;
         end
      end
      result.valid  = step_en && row_end;
      result.winner = cand_col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff      <= '0;
         count_ff      <= '0;
         best_value_ff <= '0;
         best_col_ff   <= '0;
      end else begin
         taken_ff      <= taken_in;
         count_ff      <= count_in;
         best_value_ff <= best_value_in;
         best_col_ff   <= best_col_in;
      end
   end

   assign taken_mask = taken_ff;

endmodule

`default_nettype wire

// ===== src/grca_out_stage.sv =====
`default_nettype none

module grca_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire grca_pkg::result_type result,
   output logic                      take_ok,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output grca_pkg::col_type         rsp_winner_column
);
   import grca_pkg::*;

   logic    valid_ff, valid_in;
   col_type winner_ff, winner_in;

   always_comb begin
      take_ok   = !valid_ff || rsp_ready;
      valid_in  = valid_ff && !rsp_ready;
      winner_in = winner_ff;
      if (result.valid) begin
         valid_in  = 1'b1;
         winner_in = result.winner;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      winner_ff <= winner_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_winner_column = winner_ff;

endmodule

`default_nettype wire

// ===== src/greedy_row_column_assignment_core.sv =====
`default_nettype none

// Greedy row-by-row column assignment. Costs stream in one per transfer, in column
// order; a transfer with row end set closes the row, and its winning column appears
// on the result channel in the next cycle. One cost is taken every cycle while the
// result register is empty or being drained, since the whole per-cost step, a signed
// 32-bit compare against the running best and a test of the taken mask, sits between
// the input transfer and the state and result registers.
module greedy_row_column_assignment_core #(
   parameter int MAX_COLS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire grca_pkg::cost_type req_cost_value,
   input  wire logic               req_row_end,
   input  wire logic               req_matrix_end,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output grca_pkg::col_type       rsp_winner_column
);
   import grca_pkg::*;

   localparam int ColLimit = (MAX_COLS < MaskCols) ? MAX_COLS : MaskCols;

   logic       step_en;
   result_type result;
   mask_type   taken_mask;

   assign step_en = req_valid && req_ready;

   grca_search #(
      .MAX_COLS(MAX_COLS)
   ) u_search (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .cost_value (req_cost_value),
      .row_end    (req_row_end),
      .matrix_end (req_matrix_end),
      .result     (result),
      .taken_mask (taken_mask)
   );

   grca_out_stage u_out (
      .clock             (clock),
      .reset             (reset),
      .result            (result),
      .take_ok           (req_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_winner_column (rsp_winner_column)
   );

`ifndef ASSERT_OFF
   a_row_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      step_en && req_row_end |=> rsp_valid)
      else $error("row end transfer did not produce a result");

   a_winner_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({2'b00, rsp_winner_column} < 7'(ColLimit)))
      else $error("winner column beyond column limit");

   a_matrix_end_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && req_row_end && req_matrix_end |=> taken_mask == '0)
      else $error("taken mask not cleared at matrix end");

   a_row_marks_taken: assert property (@(posedge clock) disable iff (reset)
      step_en && req_row_end && !req_matrix_end |=> taken_mask[rsp_winner_column])
      else $error("winning column not marked taken");
`endif

endmodule

`default_nettype wire
